FILE: rtl/core/ubd_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator package
// Shared widths, constants, codes, payload structs and prescaler decode.
// ----------------------------------------------------------------------------
package ubd_pkg;

	// Channel payload widths
	localparam int BAUD_W     = 24;
	localparam int WORD_W     = 16;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Datapath widths
	localparam int CLK_W   = 24;   // source clock in Hz
	localparam int SHIFT_W = 4;    // combined prescaler shift, 0..13
	localparam int NUM_W   = 29;   // 25 * pclk, at most 4e8
	localparam int DEN_W   = 26;   // 2 or 4 times the baud rate
	localparam int QUO_W   = 28;   // scaled divisor, at most 2e8 for a nonzero baud
	localparam int QLO_W   = 19;   // scaled divisor when the mantissa fits
	localparam int MANT_W  = 12;
	localparam int FRAC_W  = 4;
	localparam int REM_W   = 7;    // remainder modulo 100

	localparam logic [CLK_W-1:0] CLK_INTERNAL_HZ = 24'd16000000;
	localparam logic [CLK_W-1:0] CLK_EXTERNAL_HZ = 24'd8000000;
	localparam logic [NUM_W-1:0] SCALE_NUM       = 29'd25;

	// Scaled divisor above this gives a mantissa beyond 4095
	localparam logic [QUO_W-1:0] SCALED_LIMIT = 28'd409599;

	// Division by 100 through a reciprocal: exact for 19-bit dividends
	localparam int                    MANT_PROD_W      = 39;
	localparam int                    MANT_RECIP_SHIFT = 26;
	localparam logic [19:0]           MANT_RECIP       = 20'd671089;
	localparam logic [REM_W-1:0]      DIGIT_BASE       = 7'd100;

	// Division by 100 through a reciprocal: exact for 11-bit dividends
	localparam int                    FRAC_NUM_W       = 11;
	localparam int                    FRAC_PROD_W      = 23;
	localparam int                    FRAC_RECIP_SHIFT = 18;
	localparam int                    FRAC_Q_W         = 5;
	localparam logic [11:0]           FRAC_RECIP       = 12'd2622;
	localparam logic [FRAC_NUM_W-1:0] ROUND_HALF       = 11'd50;

	// Clock source select codes
	localparam logic [1:0] CLKSRC_INTERNAL = 2'd0;
	localparam logic [1:0] CLKSRC_EXTERNAL = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CLOCK = 2'd1,
		ST_ZERO_BAUD = 2'd2,
		ST_OVERFLOW  = 2'd3
	} ubd_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOCK_SOURCE = 2'd0,
		REG_AHB_PRESCALE = 2'd1,
		REG_APB_PRESCALE = 2'd2,
		REG_OVERSAMPLE   = 2'd3
	} ubd_cfg_idx_t;

	typedef struct packed {
		logic [1:0] clock_source;
		logic [3:0] ahb_prescale_code;
		logic [2:0] apb_prescale_code;
		logic       oversample_by_eight;
	} ubd_cfg_t;

	// Per-item sideband carried alongside the divider
	typedef struct packed {
		ubd_status_t status;
		logic        os8;
	} ubd_side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		ubd_side_t        side;
	} ubd_div_req_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo;
		ubd_side_t        side;
	} ubd_div_rsp_t;

	// AHB divider as a right shift: 2,4,8,16,64,128,256,512
	function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [3:0] code);
		logic [SHIFT_W-1:0] sh;
		case (code)
			4'd8:    sh = 4'd1;
			4'd9:    sh = 4'd2;
			4'd10:   sh = 4'd3;
			4'd11:   sh = 4'd4;
			4'd12:   sh = 4'd6;
			4'd13:   sh = 4'd7;
			4'd14:   sh = 4'd8;
			4'd15:   sh = 4'd9;
			default: sh = 4'd0;
		endcase
		return sh;
	endfunction

	// APB1 divider as a right shift: 2,4,8,16
	function automatic logic [SHIFT_W-1:0] apb_shift(input logic [2:0] code);
		logic [SHIFT_W-1:0] sh;
		case (code)
			3'd4:    sh = 4'd1;
			3'd5:    sh = 4'd2;
			3'd6:    sh = 4'd3;
			3'd7:    sh = 4'd4;
			default: sh = 4'd0;
		endcase
		return sh;
	endfunction

endpackage

FILE: rtl/core/ubd_if.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ubd_req_if import ubd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BAUD_W-1:0] baud_rate;

	modport source (output valid, output baud_rate, input ready);
	modport sink (input valid, input baud_rate, output ready);
endinterface

interface ubd_rsp_if import ubd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   divisor_word;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output divisor_word, output status, input ready);
	modport sink (input valid, input divisor_word, input status, output ready);
endinterface

interface ubd_cfg_if import ubd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ubd_front.sv
// ----------------------------------------------------------------------------
// UART baud divisor front stage
// Derive the peripheral clock, build dividend and divisor, flag early errors.
// ----------------------------------------------------------------------------
module ubd_front import ubd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  ubd_cfg_t     cfg,
	ubd_req_if.sink      req,
	output logic         out_valid,
	input  logic         out_ready,
	output ubd_div_req_t out_item
);

	logic               vld_s1;
	ubd_div_req_t       item_s1;
	logic [CLK_W-1:0]   sysclk;
	logic [SHIFT_W-1:0] shift;
	logic [CLK_W-1:0]   pclk;
	ubd_div_req_t       item_c;

	always_comb begin
		case (cfg.clock_source)
			CLKSRC_INTERNAL: sysclk = CLK_INTERNAL_HZ;
			CLKSRC_EXTERNAL: sysclk = CLK_EXTERNAL_HZ;
			default:         sysclk = '0;
		endcase
		// Both prescalers are powers of two: truncating twice equals one shift
		shift = ahb_shift(cfg.ahb_prescale_code) + apb_shift(cfg.apb_prescale_code);
		pclk  = sysclk >> shift;

		item_c.num = NUM_W'(pclk) * SCALE_NUM;
		if (cfg.oversample_by_eight) begin
			item_c.den = DEN_W'({req.baud_rate, 1'b0});
		end else begin
			item_c.den = {req.baud_rate, 2'b00};
		end
		item_c.side.os8 = cfg.oversample_by_eight;
		if (cfg.clock_source != CLKSRC_INTERNAL && cfg.clock_source != CLKSRC_EXTERNAL) begin
			item_c.side.status = ST_BAD_CLOCK;
		end else if (req.baud_rate == '0) begin
			item_c.side.status = ST_ZERO_BAUD;
		end else begin
			item_c.side.status = ST_OK;
		end
	end

	assign req.ready = ~vld_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready) begin
			item_s1 <= item_c;
		end
	end

	assign out_valid = vld_s1;
	assign out_item  = item_s1;

	// An item headed for the divider with good status never divides by zero
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && item_s1.side.status == ST_OK |-> item_s1.den != '0)
		else $error("ubd_front: zero divisor on an item with good status");

endmodule

FILE: rtl/core/ubd_div.sv
// ----------------------------------------------------------------------------
// UART baud divisor pipelined divider
// Restoring division, STEPS_PER_STAGE quotient bits per register stage (the last may take fewer).
// ----------------------------------------------------------------------------
module ubd_div import ubd_pkg::*; #(
	parameter int STEPS_PER_STAGE = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ubd_div_req_t in_item,
	output logic         out_valid,
	input  logic         out_ready,
	output ubd_div_rsp_t out_item
);

	localparam int NS = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	typedef struct packed {
		logic [DEN_W-1:0] rem;    // partial remainder, below the divisor
		logic [QUO_W-1:0] bits;   // dividend bits still to bring down, MSB first
		logic [QUO_W-1:0] quo;    // quotient bits produced so far
	} div_state_t;

	function automatic int stage_steps(input int k);
		int left;
		left = QUO_W - k * STEPS_PER_STAGE;
		return (left < STEPS_PER_STAGE) ? left : STEPS_PER_STAGE;
	endfunction

	function automatic div_state_t div_steps(input div_state_t cur,
			input logic [DEN_W-1:0] den, input int cnt);
		div_state_t       st;
		logic [DEN_W:0]   trial;
		st = cur;
		for (int j = 0; j < STEPS_PER_STAGE; j++) begin
			if (j < cnt) begin
				trial = {st.rem, st.bits[QUO_W-1]};
				if (trial >= {1'b0, den}) begin
					st.rem = DEN_W'(trial - {1'b0, den});
					st.quo = {st.quo[QUO_W-2:0], 1'b1};
				end else begin
					st.rem = trial[DEN_W-1:0];
					st.quo = {st.quo[QUO_W-2:0], 1'b0};
				end
				st.bits = st.bits << 1;
			end
		end
		return st;
	endfunction

	logic [NS-1:0]    vld_s;
	div_state_t       st_s   [NS];
	logic [DEN_W-1:0] den_s  [NS];
	ubd_side_t        side_s [NS];

	logic [NS:0]      load;
	logic [NS-1:0]    src_vld;
	div_state_t       src_st   [NS];
	logic [DEN_W-1:0] src_den  [NS];
	ubd_side_t        src_side [NS];
	div_state_t       nxt_st   [NS];

	always_comb begin
		// The top dividend bit seeds the remainder; it is below any nonzero divisor
		src_vld[0]       = in_valid;
		src_st[0].rem    = DEN_W'(in_item.num[NUM_W-1]);
		src_st[0].bits   = in_item.num[QUO_W-1:0];
		src_st[0].quo    = '0;
		src_den[0]       = in_item.den;
		src_side[0]      = in_item.side;
		for (int k = 1; k < NS; k++) begin
			src_vld[k]  = vld_s[k-1];
			src_st[k]   = st_s[k-1];
			src_den[k]  = den_s[k-1];
			src_side[k] = side_s[k-1];
		end
		for (int k = 0; k < NS; k++) begin
			nxt_st[k] = div_steps(src_st[k], src_den[k], stage_steps(k));
		end
	end

	// A stage loads when it is empty or its successor loads
	always_comb begin
		load[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			load[k] = ~vld_s[k] | load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (load[k]) begin
					vld_s[k] <= src_vld[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (load[k]) begin
				st_s[k]   <= nxt_st[k];
				den_s[k]  <= src_den[k];
				side_s[k] <= src_side[k];
			end
		end
	end

	assign in_ready      = load[0];
	assign out_valid     = vld_s[NS-1];
	assign out_item.quo  = st_s[NS-1].quo;
	assign out_item.side = side_s[NS-1];

	// Restoring division keeps the final remainder below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && side_s[NS-1].status == ST_OK |-> st_s[NS-1].rem < den_s[NS-1])
		else $error("ubd_div: final remainder not below divisor");

endmodule

FILE: rtl/core/ubd_post.sv
// ----------------------------------------------------------------------------
// UART baud divisor back end
// Split the scaled divisor into mantissa and rounded fraction, pack the word.
// ----------------------------------------------------------------------------
module ubd_post import ubd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ubd_div_rsp_t in_item,
	ubd_rsp_if.source    rsp
);

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic                   ld1, ld2, ld3, ld4;

	logic [MANT_PROD_W-1:0] prod_s1;
	logic [QLO_W-1:0]       qlo_s1;
	ubd_side_t              side_s1;
	logic [MANT_W-1:0]      mant_s2;
	logic [REM_W-1:0]       rem_s2;
	ubd_side_t              side_s2;
	logic [FRAC_PROD_W-1:0] fprod_s3;
	logic [MANT_W-1:0]      mant_s3;
	ubd_side_t              side_s3;
	logic [WORD_W-1:0]      word_s4;
	ubd_status_t            status_s4;

	ubd_side_t              side_c1;
	logic [MANT_PROD_W-1:0] prod_c1;
	logic [MANT_W-1:0]      mant_c2;
	logic [QLO_W-1:0]       mant_x100;
	logic [QLO_W-1:0]       diff_c2;
	logic [FRAC_NUM_W-1:0]  fnum_c3;
	logic [FRAC_PROD_W-1:0] fprod_c3;
	logic [FRAC_Q_W-1:0]    fq_c4;
	logic [FRAC_W-1:0]      frac_c4;
	logic [WORD_W-1:0]      word_c4;

	always_comb begin
		// Stage 1: overflow check, mantissa by reciprocal multiply
		side_c1 = in_item.side;
		if (in_item.side.status == ST_OK && in_item.quo > SCALED_LIMIT) begin
			side_c1.status = ST_OVERFLOW;
		end
		prod_c1 = MANT_PROD_W'(in_item.quo[QLO_W-1:0]) * MANT_PROD_W'(MANT_RECIP);

		// Stage 2: remainder modulo 100
		mant_c2   = prod_s1[MANT_RECIP_SHIFT +: MANT_W];
		mant_x100 = QLO_W'(mant_c2) * QLO_W'(DIGIT_BASE);
		diff_c2   = qlo_s1 - mant_x100;

		// Stage 3: round the remainder to eighths or sixteenths
		if (side_s2.os8) begin
			fnum_c3 = FRAC_NUM_W'({rem_s2, 3'b000}) + ROUND_HALF;
		end else begin
			fnum_c3 = {rem_s2, 4'b0000} + ROUND_HALF;
		end
		fprod_c3 = FRAC_PROD_W'(fnum_c3) * FRAC_PROD_W'(FRAC_RECIP);

		// Stage 4: mask the fraction, dropping any carry, and pack
		fq_c4 = fprod_s3[FRAC_RECIP_SHIFT +: FRAC_Q_W];
		if (side_s3.os8) begin
			frac_c4 = {1'b0, fq_c4[2:0]};
		end else begin
			frac_c4 = fq_c4[FRAC_W-1:0];
		end
		if (side_s3.status == ST_OK) begin
			word_c4 = {mant_s3, frac_c4};
		end else begin
			word_c4 = '0;
		end
	end

	assign ld4      = ~vld_s4 | rsp.ready;
	assign ld3      = ~vld_s3 | ld4;
	assign ld2      = ~vld_s2 | ld3;
	assign ld1      = ~vld_s1 | ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= in_valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			prod_s1 <= prod_c1;
			qlo_s1  <= in_item.quo[QLO_W-1:0];
			side_s1 <= side_c1;
		end
		if (ld2) begin
			mant_s2 <= mant_c2;
			rem_s2  <= diff_c2[REM_W-1:0];
			side_s2 <= side_s1;
		end
		if (ld3) begin
			fprod_s3 <= fprod_c3;
			mant_s3  <= mant_s2;
			side_s3  <= side_s2;
		end
		if (ld4) begin
			word_s4   <= word_c4;
			status_s4 <= side_s3.status;
		end
	end

	assign rsp.valid        = vld_s4;
	assign rsp.divisor_word = word_s4;
	assign rsp.status       = status_s4;

	a_err_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.divisor_word == '0)
		else $error("ubd_post: nonzero divisor word on an error result");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && side_s2.status == ST_OK |-> rem_s2 < DIGIT_BASE)
		else $error("ubd_post: remainder modulo 100 out of range");

endmodule

FILE: rtl/core/uart_baud_divisor_calc.sv
// ----------------------------------------------------------------------------
// UART fractional baud divisor calculator
// Turns a requested baud rate into the 16-bit mantissa/fraction divisor word.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  - register writes (index, data); always ready. Write only while no
//          item is in flight. Index 0 clock source, 1 AHB prescale code,
//          2 APB1 prescale code, 3 oversample-by-8 enable.
//   req  - one item per accepted baud_rate.
//   rsp  - one item per request, in order: divisor_word and status
//          (0 ok, 1 unsupported clock source, 2 zero baud, 3 mantissa overflow).
// Throughput: one item per cycle while rsp is not held. Pipeline: a front stage,
//   the restoring divider with one register stage per STEPS_PER_STAGE
//   quotient bits, and four back-end stages.
// Stalls: every stage carries a valid bit and loads when empty or when its
//   successor loads, so bubbles close up and req stays ready while rsp is
//   held, until the pipeline is full. Nothing is dropped or repeated.
// Reset: clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc import ubd_pkg::*; #(
	parameter int STEPS_PER_STAGE = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	ubd_cfg_if.sink   cfg,
	ubd_req_if.sink   req,
	ubd_rsp_if.source rsp
);

	ubd_cfg_t     cfg_q;

	logic         front_valid;
	logic         front_ready;
	ubd_div_req_t front_item;
	logic         div_valid;
	logic         div_ready;
	ubd_div_rsp_t div_item;

	// Register writes are taken every cycle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CLOCK_SOURCE: cfg_q.clock_source        <= cfg.data[1:0];
				REG_AHB_PRESCALE: cfg_q.ahb_prescale_code   <= cfg.data[3:0];
				REG_APB_PRESCALE: cfg_q.apb_prescale_code   <= cfg.data[2:0];
				REG_OVERSAMPLE:   cfg_q.oversample_by_eight <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Front: peripheral clock, dividend 25*pclk, divisor 2 or 4 times baud
	ubd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	// Divider: scaled divisor, errors ride along as sideband
	ubd_div #(
		.STEPS_PER_STAGE (STEPS_PER_STAGE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_item  (div_item)
	);

	// Back end: mantissa, rounded fraction, overflow, output register
	ubd_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_item  (div_item),
		.rsp      (rsp)
	);

endmodule
